// ===== src/evint_pkg.sv =====
// Shared types and constants for the EBML variable-length integer encoder.
`default_nettype none

package evint_pkg;

  // Request codes
  localparam logic [1:0] REQ_AUTO  = 2'd0;
  localparam logic [1:0] REQ_FIXED = 2'd1;
  localparam logic [1:0] REQ_SIZE  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_SMALL = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;

  localparam logic [3:0] MAX_LEN = 4'd8;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] value;
    logic [3:0]  length_arg;
  } evint_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic [1:0] status;
    logic [3:0] length;
  } evint_out_t;

  // Request plus its automatic length (9 when the value fits no length)
  typedef struct packed {
    evint_in_t  item;
    logic [3:0] n_auto;
  } evint_sized_t;

  // Work handed to the byte serializer
  typedef struct packed {
    logic [63:0] data;    // bytes to send, first byte in the top bits
    logic [2:0]  cnt;     // results left after the current one
    logic [1:0]  status;
    logic [3:0]  length;
  } evint_job_t;

endpackage

`default_nettype wire

// ===== src/evint_len_stage.sv =====
// Stage one: input register and automatic length search.
`default_nettype none

module evint_len_stage (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  load,
  input  wire logic                  drain,
  input  wire evint_pkg::evint_in_t  in_item,
  output logic                       valid,
  output evint_pkg::evint_sized_t    sized
);

  logic                 valid_r;
  evint_pkg::evint_in_t item_r;
  logic [3:0]           n_auto;

  // Hold the accepted item until the next stage takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (drain) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  // Find the highest nonzero 7-bit group; anything in the top byte needs nine
  always_comb begin
    n_auto = 4'd1;
    for (int k = 1; k < 8; k++) begin
      if (|item_r.value[7*k +: 7]) begin
        n_auto = 4'(k + 1);
      end
    end
    if (|item_r.value[63:56]) begin
      n_auto = 4'd9;
    end
  end

  assign valid        = valid_r;
  assign sized.item   = item_r;
  assign sized.n_auto = n_auto;

endmodule

`default_nettype wire

// ===== src/evint_plan_stage.sv =====
// Stage two: length choice, range checks, byte alignment and marker.
`default_nettype none

module evint_plan_stage (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    load,
  input  wire logic                    drain,
  input  wire evint_pkg::evint_sized_t sized,
  output logic                         valid,
  output evint_pkg::evint_job_t        job
);

  logic                    valid_r;
  evint_pkg::evint_sized_t sized_r;
  logic [3:0]              n_sel;
  logic [2:0]              n_m1;
  logic [63:0]             shifted;
  logic [7:0]              marker;
  logic [7:0]              top;
  logic [3:0]              cap;
  logic                    fixed_bad;

  // Hold the sized item until the serializer takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (drain) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sized_r <= sized;
    end
  end

  // Align the kept bytes to the top of the word and build the marker
  always_comb begin
    n_sel   = (sized_r.item.req_type == evint_pkg::REQ_FIXED) ?
              sized_r.item.length_arg : sized_r.n_auto;
    n_m1    = 3'(n_sel - 4'd1);
    shifted = sized_r.item.value << {~n_m1, 3'b000};
    marker  = 8'h80 >> n_m1;
    top     = shifted[63:56];
    cap     = (sized_r.item.length_arg > evint_pkg::MAX_LEN) ?
              evint_pkg::MAX_LEN : sized_r.item.length_arg;
    fixed_bad = (sized_r.item.length_arg == 4'd0) ||
                (sized_r.item.length_arg > evint_pkg::MAX_LEN) ||
                (top >= marker);
  end

  // Decide between a byte sequence and a single status result
  always_comb begin
    job.data   = '0;
    job.cnt    = '0;
    job.status = evint_pkg::ST_OK;
    job.length = '0;
    if (sized_r.item.req_type == evint_pkg::REQ_FIXED) begin
      if (fixed_bad) begin
        job.status = evint_pkg::ST_RANGE;
      end else begin
        job.data   = {top | marker, shifted[55:0]};
        job.cnt    = n_m1;
        job.length = n_sel;
      end
    end else if (sized_r.n_auto > cap) begin
      job.status = evint_pkg::ST_TOO_SMALL;
    end else if (sized_r.item.req_type == evint_pkg::REQ_AUTO) begin
      job.data   = {top | marker, shifted[55:0]};
      job.cnt    = n_m1;
      job.length = n_sel;
    end else begin
      job.length = sized_r.n_auto;
    end
  end

  assign valid = valid_r;

endmodule

`default_nettype wire

// ===== src/evint_serializer.sv =====
// Stage three: byte serializer that drives one result per cycle.
`default_nettype none

module evint_serializer (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   load,
  input  wire evint_pkg::evint_job_t  job,
  output logic                        free,
  output logic                        out_valid,
  output evint_pkg::evint_out_t       out_item
);

  logic                  valid_r;
  logic                  valid_nxt;
  evint_pkg::evint_job_t job_r;
  evint_pkg::evint_job_t job_nxt;

  // Free when empty or when the current result is the item's last
  assign free = !valid_r || (job_r.cnt == 3'd0);

  // Load a new item, advance to the next byte, or drop the finished one
  always_comb begin
    valid_nxt = valid_r;
    job_nxt   = job_r;
    if (load) begin
      valid_nxt = 1'b1;
      job_nxt   = job;
    end else if (valid_r && (job_r.cnt != 3'd0)) begin
      job_nxt.data = {job_r.data[55:0], 8'h00};
      job_nxt.cnt  = job_r.cnt - 3'd1;
    end else begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  assign out_valid         = valid_r;
  assign out_item.out_byte = job_r.data[63:56];
  assign out_item.last     = (job_r.cnt == 3'd0);
  assign out_item.status   = job_r.status;
  assign out_item.length   = job_r.length;

  // A byte that is not the last is followed by the next byte of the same item
  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && (job_r.cnt != 3'd0) |=> valid_r && (job_r.length == $past(job_r.length)))
    else $error("serializer burst broken");

  // Error results are single, zero and lengthless
  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && (job_r.status != evint_pkg::ST_OK) |->
      (job_r.cnt == 3'd0) && (job_r.length == 4'd0) && (job_r.data[63:56] == 8'h00))
    else $error("malformed error result");

  // Never load over a byte that still has followers
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("serializer overwritten");

endmodule

`default_nettype wire

// ===== src/ebml_vint_encoder_core.sv =====
// An item passes the stage one, stage two and serializer registers to the ports.
// Throughput: one item per cycle for single-result items while the serializer is
// free; an n-byte encode holds it to its last byte; the output port sets the rate.
// busy rises when the serializer is mid-burst and both stage registers are full.
// Reset (synchronous, active low) empties all stages; no result is pending.
// Results cannot be held off by the receiver.
`default_nettype none

module ebml_vint_encoder_core (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire evint_pkg::evint_in_t  in_item,
  output logic                       out_valid,
  output evint_pkg::evint_out_t      out_item
);

  logic                    s1_valid;
  logic                    s2_valid;
  logic                    ser_free;
  logic                    s1_ready;
  logic                    s2_ready;
  logic                    s1_move;
  logic                    s2_move;
  logic                    accept;
  evint_pkg::evint_sized_t sized;
  evint_pkg::evint_job_t   job;

  // Stall chain: a stage takes a new item when empty or when it is passing one on
  assign s2_move  = s2_valid && ser_free;
  assign s2_ready = !s2_valid || ser_free;
  assign s1_move  = s1_valid && s2_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign busy     = !s1_ready;
  assign accept   = start && !busy;

  evint_len_stage u_len (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (accept),
    .drain   (s1_move),
    .in_item (in_item),
    .valid   (s1_valid),
    .sized   (sized)
  );

  evint_plan_stage u_plan (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (s1_move),
    .drain (s2_move),
    .sized (sized),
    .valid (s2_valid),
    .job   (job)
  );

  evint_serializer u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s2_move),
    .job       (job),
    .free      (ser_free),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // An accepted item is held in stage one on the next cycle
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid)
    else $error("accepted item lost");

  // busy only when stage one holds an item that cannot move
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> s1_valid && s2_valid && !ser_free)
    else $error("spurious busy");

  // A waiting stage two item keeps its place while the serializer is occupied
  a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid && !ser_free |=> s2_valid)
    else $error("stage two item dropped");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the EBML variable-length integer encoder core.

module tb_top;

  // The request code left unused by the package acts as a size query
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int NUM_DIR      = 25;
  localparam int NUM_RAND     = 195;
  localparam int IDLE_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 10;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MAX_8B   = 64'h00FF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEEDS_9B = 64'h0100_0000_0000_0000;

  localparam evint_pkg::evint_out_t NO_WANT        = '0;
  localparam evint_pkg::evint_out_t WANT_TOO_SMALL =
    {8'h00, 1'b1, evint_pkg::ST_TOO_SMALL, 4'd0};
  localparam evint_pkg::evint_out_t WANT_RANGE     =
    {8'h00, 1'b1, evint_pkg::ST_RANGE, 4'd0};

  typedef struct packed {
    evint_pkg::evint_in_t  item;
    logic                  has_want;
    evint_pkg::evint_out_t want;
  } vint_case_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  evint_pkg::evint_in_t  in_item;
  logic                  out_valid;
  evint_pkg::evint_out_t out_item;

  evint_pkg::evint_out_t expected_bytes[$];
  int         mismatches = 0;
  int         idle_cycles = 0;
  bit         no_gaps = 1'b0;

  // Directed items: extremes, every request type and each corner case
  vint_case_t dir_cases [NUM_DIR] = '{
    {evint_pkg::REQ_AUTO,  64'd0,    4'd8, 1'b1, 8'h80, 1'b1, evint_pkg::ST_OK, 4'd1},
    {evint_pkg::REQ_AUTO,  64'd127,  4'd1, 1'b1, 8'hFF, 1'b1, evint_pkg::ST_OK, 4'd1},
    {evint_pkg::REQ_AUTO,  64'd128,  4'd2,  1'b0, NO_WANT},
    {evint_pkg::REQ_AUTO,  MAX_8B,   4'd8,  1'b0, NO_WANT},
    {evint_pkg::REQ_AUTO,  NEEDS_9B, 4'd8,  1'b1, WANT_TOO_SMALL},
    {evint_pkg::REQ_AUTO,  ALL_ONES, 4'd15, 1'b1, WANT_TOO_SMALL},
    {evint_pkg::REQ_AUTO,  64'd128,  4'd1,  1'b1, WANT_TOO_SMALL},
    {evint_pkg::REQ_AUTO,  64'd5,    4'd0,  1'b1, WANT_TOO_SMALL},
    {evint_pkg::REQ_AUTO,  64'h0000_0000_0012_3456, 4'd12, 1'b0, NO_WANT},
    {evint_pkg::REQ_FIXED, 64'd0,    4'd8,  1'b0, NO_WANT},
    {evint_pkg::REQ_FIXED, 64'h7F,   4'd1, 1'b1, 8'hFF, 1'b1, evint_pkg::ST_OK, 4'd1},
    {evint_pkg::REQ_FIXED, 64'h80,   4'd1,  1'b1, WANT_RANGE},
    {evint_pkg::REQ_FIXED, 64'd0,    4'd0,  1'b1, WANT_RANGE},
    {evint_pkg::REQ_FIXED, 64'd0,    4'd9,  1'b1, WANT_RANGE},
    {evint_pkg::REQ_FIXED, 64'd1,    4'd15, 1'b1, WANT_RANGE},
    {evint_pkg::REQ_FIXED, ALL_ONES, 4'd8,  1'b1, WANT_RANGE},
    {evint_pkg::REQ_FIXED, 64'hDEAD_BEEF_0000_3FFF, 4'd2, 1'b0, NO_WANT},
    {evint_pkg::REQ_FIXED, 64'h4000, 4'd2,  1'b1, WANT_RANGE},
    {evint_pkg::REQ_FIXED, 64'h0001_4567_89AB_CDEF, 4'd7, 1'b0, NO_WANT},
    {evint_pkg::REQ_SIZE,  64'd0,    4'd1, 1'b1, 8'h00, 1'b1, evint_pkg::ST_OK, 4'd1},
    {evint_pkg::REQ_SIZE,  MAX_8B,   4'd8, 1'b1, 8'h00, 1'b1, evint_pkg::ST_OK, 4'd8},
    {evint_pkg::REQ_SIZE,  NEEDS_9B, 4'd8,  1'b1, WANT_TOO_SMALL},
    {evint_pkg::REQ_SIZE,  64'd300,  4'd0,  1'b1, WANT_TOO_SMALL},
    {REQ_UNUSED,           64'd1000, 4'd9, 1'b1, 8'h00, 1'b1, evint_pkg::ST_OK, 4'd2},
    {REQ_UNUSED,           ALL_ONES, 4'd3,  1'b1, WANT_TOO_SMALL}
  };

  ebml_vint_encoder_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] rand_word64();
    return {$urandom, $urandom};
  endfunction

  function automatic void push_byte(input logic [7:0] b, input logic last,
                                    input logic [1:0] status, input logic [3:0] len);
    evint_pkg::evint_out_t r;
    r.out_byte = b;
    r.last     = last;
    r.status   = status;
    r.length   = len;
    expected_bytes.push_back(r);
  endfunction

  // Least byte count whose 7 data bits per byte hold the value; 9 if none
  function automatic logic [3:0] vint_auto_len(input logic [63:0] v);
    logic [3:0] n;
    for (n = 4'd1; n <= 4'd8; n++) begin
      if ((v >> (7 * n)) == 64'd0) return n;
    end
    return 4'd9;
  endfunction

  // Queue the bytes of an n-byte encoding, marker bit merged into the first
  function automatic void emit_vint(input logic [63:0] v, input logic [3:0] len);
    int          nb;
    logic [63:0] shifted;
    logic [7:0]  b;
    nb = int'(len);
    for (int k = 0; k < nb; k++) begin
      shifted = v >> (8 * (nb - 1 - k));
      b = shifted[7:0];
      if (k == 0) b = b | (8'd1 << (8 - nb));
      push_byte(b, k == nb - 1, evint_pkg::ST_OK, len);
    end
  endfunction

  function automatic void predict_encoding(input evint_pkg::evint_in_t it);
    int          larg;
    logic [63:0] shifted;
    logic [8:0]  marker;
    logic [3:0]  n;
    logic [3:0]  cap;
    larg = int'(it.length_arg);
    if (it.req_type == evint_pkg::REQ_FIXED) begin
      if (larg < 1 || larg > int'(evint_pkg::MAX_LEN)) begin
        push_byte(8'h00, 1'b1, evint_pkg::ST_RANGE, 4'd0);
        return;
      end
      shifted = it.value >> (8 * (larg - 1));
      marker = 9'd1 << (8 - larg);
      // top kept byte must stay below the marker bit
      if ({1'b0, shifted[7:0]} >= marker) push_byte(8'h00, 1'b1, evint_pkg::ST_RANGE, 4'd0);
      else emit_vint(it.value, it.length_arg);
    end else begin
      n = vint_auto_len(it.value);
      cap = (it.length_arg > evint_pkg::MAX_LEN) ? evint_pkg::MAX_LEN : it.length_arg;
      if (n > cap) push_byte(8'h00, 1'b1, evint_pkg::ST_TOO_SMALL, 4'd0);
      else if (it.req_type == evint_pkg::REQ_AUTO) emit_vint(it.value, n);
      else push_byte(8'h00, 1'b1, evint_pkg::ST_OK, n);
    end
  endfunction

  // Mostly well-formed requests with random content, some bad lengths and overflow
  function automatic evint_pkg::evint_in_t rand_item();
    evint_pkg::evint_in_t it;
    int          sel;
    int          nb;
    logic [63:0] v;
    sel = $urandom_range(0, 99);
    nb = $urandom_range(1, 8);
    v = rand_word64();
    if ($urandom_range(0, 9) != 0) v = v & ((64'd1 << (7 * nb)) - 64'd1);
    if (sel < 45) begin
      it.req_type = evint_pkg::REQ_AUTO;
      if ($urandom_range(0, 9) != 0) it.length_arg = 4'($urandom_range(nb, 15));
      else it.length_arg = 4'($urandom_range(0, 15));
    end else if (sel < 80) begin
      it.req_type = evint_pkg::REQ_FIXED;
      if ($urandom_range(0, 6) != 0) begin
        it.length_arg = 4'(nb);
        // fill the bytes above the kept length with junk to be dropped
        if (nb < 8 && $urandom_range(0, 1) == 1) v = v | (rand_word64() << (8 * nb));
      end else begin
        it.length_arg = 4'($urandom_range(0, 15));
      end
    end else begin
      it.req_type = ($urandom_range(0, 3) != 0) ? evint_pkg::REQ_SIZE : REQ_UNUSED;
      it.length_arg = 4'($urandom_range(0, 15));
    end
    it.value = v;
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input evint_pkg::evint_in_t it, input logic has_want,
                           input evint_pkg::evint_out_t want);
    int                   gap;
    evint_pkg::evint_in_t noise;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      noise.req_type   = 2'($urandom_range(0, 3));
      noise.value      = rand_word64();
      noise.length_arg = 4'($urandom_range(0, 15));
      start   <= 1'b0;
      in_item <= noise;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (has_want) expected_bytes.push_back(want);
    else predict_encoding(it);
    @(negedge clk);
  endtask

  // Hold off the sender until every queued byte has come out
  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (expected_bytes.size() != 0);
  endtask

  // Compare each output byte with the oldest expected one
  always @(posedge clk) begin
    evint_pkg::evint_out_t want;
    if (rst_n && out_valid) begin
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result byte=%h last=%b status=%0d length=%0d",
                   $realtime, out_item.out_byte, out_item.last, out_item.status,
                   out_item.length);
      end else begin
        want = expected_bytes.pop_front();
        if (out_item.out_byte !== want.out_byte || out_item.last !== want.last ||
            out_item.status !== want.status || out_item.length !== want.length) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch byte=%h/%h last=%b/%b status=%0d/%0d length=%0d/%0d",
                     $realtime, out_item.out_byte, want.out_byte, out_item.last, want.last,
                     out_item.status, want.status, out_item.length, want.length);
        end
      end
    end
  end

  // Abort when nothing moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    vint_case_t row;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_cases[i]) begin
      row = dir_cases[i];
      send_item(row.item, row.has_want, row.want);
    end
    wait_drained();

    for (int i = 0; i < NUM_RAND; i++) begin
      // back-to-back stretch, then one full drain mid-run
      no_gaps = (i >= 60 && i < 100);
      if (i == 140) wait_drained();
      send_item(rand_item(), 1'b0, NO_WANT);
    end

    start <= 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
